// ===== rtl/csa_pkg.sv =====
// csa_pkg: shared types and constants of the cosine similarity accumulator
// transaction payload structs, datapath op codes and controller/datapath bundles
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package csa_pkg;

  localparam int DIGIT_W    = 16;
  localparam int DIV_STEPS  = 30;
  localparam int SQRT_STEPS = 15;
  localparam int D_W        = 30;
  localparam int ROOT_W     = 15;
  localparam int SR_W       = 18;
  localparam int CNT_W      = 5;
  localparam int SIM_W      = 16;

  typedef struct packed {
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic               last;
  } csa_in_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;
    logic                    overflowed;
  } csa_out_t;

  typedef enum logic [2:0] {
    OP_IDLE     = 3'd0,
    OP_PREP     = 3'd1,
    OP_MUL_P    = 3'd2,
    OP_MUL_M    = 3'd3,
    OP_DIV_INIT = 3'd4,
    OP_DIV      = 3'd5,
    OP_SQRT     = 3'd6,
    OP_DONE     = 3'd7
  } csa_op_t;

  typedef struct packed {
    csa_op_t op;
    logic    acc;
    logic    last;
  } csa_cmd_t;

  typedef struct packed {
    logic zero_norm;
  } csa_status_t;

endpackage

`default_nettype wire

// ===== rtl/csa_datapath.sv =====
// csa_datapath: accumulators, shared digit multiplier, divider and square root unit
// sequenced by csa_ctrl through csa_cmd_t; uses csa_pkg
`timescale 1ns / 1ps
`default_nettype none

module csa_datapath #(
  parameter int ACC_BITS = 56
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire csa_pkg::csa_in_t   in_data,
  input  wire csa_pkg::csa_cmd_t  cmd,
  output csa_pkg::csa_status_t    status,
  output csa_pkg::csa_out_t       out_data
);
  import csa_pkg::*;

  localparam int OPW  = ACC_BITS;
  localparam int NDIG = (OPW + DIGIT_W - 1) / DIGIT_W;
  localparam int BW   = NDIG * DIGIT_W;
  localparam int PW   = 2 * OPW;
  localparam int RW   = PW + 1;

  logic signed [OPW-1:0] dot_sum;
  logic signed [OPW-1:0] square_sum_a;
  logic signed [OPW-1:0] square_sum_b;
  logic                  overflow_seen;

  logic [OPW-1:0] mag;
  logic           neg;
  logic [OPW-1:0] mul_a;
  logic [BW-1:0]  mul_b;
  logic [PW-1:0]  mul_p;
  logic [PW-1:0]  prod;
  logic [RW-1:0]  rem;
  logic           sat;
  logic [D_W-1:0] quo;
  logic [SR_W-1:0]   sq_rem;
  logic [ROOT_W-1:0] root;

  function automatic logic [OPW:0] sat_add(input logic signed [OPW-1:0] acc,
                                           input logic signed [31:0] p);
    logic [OPW:0] s;
    s = {acc[OPW-1], acc} + (OPW+1)'(p);
    if (s[OPW] != s[OPW-1]) begin
      if (s[OPW] == 1'b0) begin
        return {1'b1, 1'b0, {(OPW-1){1'b1}}};
      end else begin
        return {1'b1, 1'b1, {(OPW-1){1'b0}}};
      end
    end
    return {1'b0, s[OPW-1:0]};
  endfunction

  logic signed [31:0] p_ab;
  logic signed [31:0] p_aa;
  logic signed [31:0] p_bb;
  logic [OPW:0]       dot_add;
  logic [OPW:0]       sqa_add;
  logic [OPW:0]       sqb_add;

  assign p_ab = in_data.sample_a * in_data.sample_b;
  assign p_aa = in_data.sample_a * in_data.sample_a;
  assign p_bb = in_data.sample_b * in_data.sample_b;
  assign dot_add = sat_add(dot_sum, p_ab);
  assign sqa_add = sat_add(square_sum_a, p_aa);
  assign sqb_add = sat_add(square_sum_b, p_bb);

  assign status.zero_norm = (square_sum_a == '0) || (square_sum_b == '0);

  // digit serial multiplier, most significant digit first
  logic [DIGIT_W-1:0]     digit;
  logic [OPW+DIGIT_W-1:0] pp;
  logic [PW-1:0]          mul_p_next;

  assign digit      = mul_b[BW-1 -: DIGIT_W];
  assign pp         = mul_a * digit;
  assign mul_p_next = (mul_p << DIGIT_W) + PW'(pp);

  // restoring divider step
  logic [RW-1:0]  r2;
  logic [RW-1:0]  prod_ext;
  logic           div_ge;
  logic [D_W-1:0] quo_next;

  assign r2       = {rem[RW-2:0], 1'b0};
  assign prod_ext = RW'(prod);
  assign div_ge   = r2 >= prod_ext;
  assign quo_next = {quo[D_W-2:0], div_ge};

  // square root step, two radicand bits per step
  logic [SR_W-1:0] sq_rem2;
  logic [SR_W-1:0] sq_trial;
  logic            sq_ge;

  assign sq_rem2  = {sq_rem[SR_W-3:0], quo[D_W-1 -: 2]};
  assign sq_trial = SR_W'({root, 2'b01});
  assign sq_ge    = sq_rem2 >= sq_trial;

  // round half up of root / 2
  logic [ROOT_W:0]        q_round;
  logic signed [SIM_W-1:0] sim_pos;

  assign q_round = {1'b0, root} + 1'b1;
  assign sim_pos = SIM_W'({1'b0, q_round[ROOT_W:1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum       <= '0;
      square_sum_a  <= '0;
      square_sum_b  <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.op == OP_DONE) begin
      dot_sum       <= '0;
      square_sum_a  <= '0;
      square_sum_b  <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.acc) begin
      dot_sum       <= dot_add[OPW-1:0];
      square_sum_a  <= sqa_add[OPW-1:0];
      square_sum_b  <= sqb_add[OPW-1:0];
      overflow_seen <= overflow_seen | dot_add[OPW] | sqa_add[OPW] | sqb_add[OPW];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_IDLE: begin
      end
      OP_PREP: begin
        neg   <= dot_sum[OPW-1];
        mag   <= dot_sum[OPW-1] ? (~$unsigned(dot_sum) + 1'b1) : $unsigned(dot_sum);
        mul_a <= $unsigned(square_sum_a);
        mul_b <= BW'($unsigned(square_sum_b));
        mul_p <= '0;
      end
      OP_MUL_P: begin
        if (cmd.last) begin
          prod  <= mul_p_next;
          mul_a <= mag;
          mul_b <= BW'(mag);
          mul_p <= '0;
        end else begin
          mul_p <= mul_p_next;
          mul_b <= mul_b << DIGIT_W;
        end
      end
      OP_MUL_M: begin
        mul_p <= mul_p_next;
        mul_b <= mul_b << DIGIT_W;
      end
      OP_DIV_INIT: begin
        rem <= RW'(mul_p);
        sat <= mul_p >= prod;
        quo <= '0;
      end
      OP_DIV: begin
        rem <= div_ge ? (r2 - prod_ext) : r2;
        if (cmd.last) begin
          quo    <= sat ? {D_W{1'b1}} : quo_next;
          sq_rem <= '0;
          root   <= '0;
        end else begin
          quo <= quo_next;
        end
      end
      OP_SQRT: begin
        sq_rem <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
        root   <= {root[ROOT_W-2:0], sq_ge};
        quo    <= quo << 2;
      end
      OP_DONE: begin
        out_data.zero_norm  <= status.zero_norm;
        out_data.overflowed <= overflow_seen;
        if (status.zero_norm) begin
          out_data.similarity <= '0;
        end else begin
          out_data.similarity <= neg ? -sim_pos : sim_pos;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_clear_after_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DONE) |=> (dot_sum == '0 && square_sum_a == '0 &&
                             square_sum_b == '0 && !overflow_seen))
    else $error("accumulators not cleared after result");
  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DONE) |=> (out_data.similarity <= 16'sd16384 &&
                             out_data.similarity >= -16'sd16384))
    else $error("similarity out of range");
  a_zero_norm_sim: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DONE) |=> (!out_data.zero_norm || out_data.similarity == '0))
    else $error("zero norm with nonzero similarity");
`endif

endmodule

`default_nettype wire

// ===== rtl/csa_ctrl.sv =====
// csa_ctrl: sequencer for accumulation and the end-of-run divide and square root
// drives csa_cmd_t to csa_datapath and owns the handshakes; uses csa_pkg
`timescale 1ns / 1ps
`default_nettype none

module csa_ctrl #(
  parameter int NUM_DIGITS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 item_last,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire csa_pkg::csa_status_t status,
  output csa_pkg::csa_cmd_t         cmd
);
  import csa_pkg::*;

  typedef enum logic [6:0] {
    ST_ACCUM    = 7'b0000001,
    ST_PREP     = 7'b0000010,
    ST_MUL_P    = 7'b0000100,
    ST_MUL_M    = 7'b0001000,
    ST_DIV_INIT = 7'b0010000,
    ST_DIV      = 7'b0100000,
    ST_SQRT     = 7'b1000000
  } csa_state_t;

  csa_state_t       state, state_next;
  logic             done;
  logic             done_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             step_last;
  logic             in_accept;

  assign in_stall  = (state != ST_ACCUM) || done || (out_valid && item_last);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    step_last = 1'b0;
    unique case (state)
      ST_MUL_P, ST_MUL_M: step_last = cnt == CNT_W'(NUM_DIGITS - 1);
      ST_DIV:             step_last = cnt == CNT_W'(DIV_STEPS - 1);
      ST_SQRT:            step_last = cnt == CNT_W'(SQRT_STEPS - 1);
      default:            step_last = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cnt_next   = step_last ? '0 : cnt + 1'b1;
    cmd.acc    = in_accept;
    cmd.last   = step_last;
    cmd.op     = OP_IDLE;
    unique case (state)
      ST_ACCUM: begin
        cnt_next = '0;
        if (done) begin
          cmd.op = OP_DONE;
        end else if (in_accept && item_last) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.op   = OP_PREP;
        cnt_next = '0;
        if (status.zero_norm) begin
          state_next = ST_ACCUM;
          done_next  = 1'b1;
        end else begin
          state_next = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.op = OP_MUL_P;
        if (step_last) state_next = ST_MUL_M;
      end
      ST_MUL_M: begin
        cmd.op = OP_MUL_M;
        if (step_last) state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (step_last) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        if (step_last) begin
          state_next = ST_ACCUM;
          done_next  = 1'b1;
        end
      end
      default: begin
        state_next = ST_ACCUM;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      cnt       <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_starts_finish: assert property (@(posedge clk) disable iff (rst)
    (in_accept && item_last) |=> (state == ST_PREP))
    else $error("last transaction did not start the finish sequence");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(done))
    else $error("result raised without a finished run");
  a_done_output_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !out_valid)
    else $error("result overwritten while still pending");
`endif

endmodule

`default_nettype wire

// ===== rtl/cosine_similarity_accumulator_unit.sv =====
// cosine_similarity_accumulator_unit: top level, one accumulated similarity per run
// ordinary items: accumulated back to back at 1 transaction per cycle while not stalled
// last item: the run finishes through the 16-bit digit multiplier (two products), the
// 30-step divider and the 15-step root, then the result is registered with out_valid;
// a zero norm run goes straight to the result; input stalls meanwhile
// reset: synchronous rst clears accumulators, overflow flag, sequencer and out_valid
`timescale 1ns / 1ps
`default_nettype none

module cosine_similarity_accumulator_unit #(
  parameter int MAX_VOXELS_LOG2 = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire csa_pkg::csa_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output csa_pkg::csa_out_t      out_data
);
  import csa_pkg::*;

  localparam int ACC_BITS   = 32 + MAX_VOXELS_LOG2;
  localparam int NUM_DIGITS = (ACC_BITS + DIGIT_W - 1) / DIGIT_W;

  csa_cmd_t    cmd;
  csa_status_t status;

  csa_ctrl #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .item_last (in_data.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  csa_datapath #(
    .ACC_BITS (ACC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
